@@ rtl/core/pbs_pkg.sv @@
// Shared types, register codes, stage plan and per-stage datapath functions for Blinn-Phong shading
`default_nettype none
package pbs_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_DIFFUSE_RED    = 3'd0;
  localparam logic [2:0] REG_DIFFUSE_GREEN  = 3'd1;
  localparam logic [2:0] REG_DIFFUSE_BLUE   = 3'd2;
  localparam logic [2:0] REG_SPECULAR_RED   = 3'd3;
  localparam logic [2:0] REG_SPECULAR_GREEN = 3'd4;
  localparam logic [2:0] REG_SPECULAR_BLUE  = 3'd5;
  localparam logic [2:0] REG_SHININESS      = 3'd6;
  localparam logic [2:0] REG_SHADE_BACK     = 3'd7;

  localparam logic [15:0] SHIN_RESET = 16'd256;
  localparam logic [14:0] Q14_ONE    = 15'd16384;
  localparam logic signed [33:0] DOT_ONE = 34'sh1000_0000;

  localparam int SQV_STEPS  = 16;
  localparam int SQH_STEPS  = 17;
  localparam int DIV_STEPS  = 15;
  localparam int PINT_STEPS = 8;
  localparam int FR_STEPS   = 15;
  localparam int FR_ROUND   = FR_STEPS + 1;
  localparam int FR_ROUNDS  = 8;

  localparam int ST_PROD      = 1;
  localparam int ST_FLIP      = ST_PROD + 1;
  localparam int ST_SQV0      = ST_FLIP + 1;
  localparam int ST_DIVV_INIT = ST_SQV0 + SQV_STEPS;
  localparam int ST_DIVV0     = ST_DIVV_INIT + 1;
  localparam int ST_DIVV_FIN  = ST_DIVV0 + DIV_STEPS;
  localparam int ST_HSQ       = ST_DIVV_FIN + 1;
  localparam int ST_HSUM      = ST_HSQ + 1;
  localparam int ST_SQH0      = ST_HSUM + 1;
  localparam int ST_DIVH_INIT = ST_SQH0 + SQH_STEPS;
  localparam int ST_DIVH0     = ST_DIVH_INIT + 1;
  localparam int ST_DIVH_FIN  = ST_DIVH0 + DIV_STEPS;
  localparam int ST_DOT       = ST_DIVH_FIN + 1;
  localparam int ST_CLAMP     = ST_DOT + 1;
  localparam int ST_PINT0     = ST_CLAMP + 1;
  localparam int ST_FRINIT    = ST_PINT0 + PINT_STEPS;
  localparam int ST_FR0       = ST_FRINIT + 1;
  localparam int ST_CH1       = ST_FR0 + FR_ROUND * FR_ROUNDS;
  localparam int ST_CH2       = ST_CH1 + 1;
  localparam int ST_CH3       = ST_CH2 + 1;
  localparam int NSTAGE       = ST_CH3 + 1;

  typedef struct packed {
    logic [2:0][16:0] n;
    logic [2:0][15:0] ray;
    logic [2:0][15:0] l;
    logic [2:0][15:0] lc;
    logic [2:0][16:0] vec;
    logic [2:0][33:0] t;
    logic [2:0][33:0] u;
    logic [34:0]      sqa;
    logic [34:0]      sqr;
    logic [16:0]      len;
    logic [2:0][31:0] rem;
    logic [2:0][14:0] quo;
    logic [2:0][15:0] hn;
    logic [14:0]      dif;
    logic [14:0]      pw_p;
    logic [14:0]      pw_s;
    logic [14:0]      pw_r;
    logic [2:0][31:0] cd;
    logic [2:0][47:0] cp;
    logic [2:0][15:0] res;
  } item_t;

  function automatic logic signed [33:0] sx17(input logic [16:0] x);
    return {{17{x[16]}}, x};
  endfunction

  function automatic logic signed [33:0] sx16(input logic [15:0] x);
    return {{18{x[15]}}, x};
  endfunction

  function automatic logic [14:0] mulq(input logic [14:0] a, input logic [14:0] b);
    logic [29:0] pa;
    logic [29:0] pb;
    logic [29:0] pr;
    pa = {15'b0, a};
    pb = {15'b0, b};
    pr = pa * pb;
    return pr[28:14];
  endfunction

  function automatic logic [14:0] clampd(input logic [33:0] a, input logic [33:0] b,
                                         input logic [33:0] c);
    logic signed [33:0] s;
    logic [14:0] r;
    s = $signed(a) + $signed(b) + $signed(c);
    if (s <= 34'sd0) begin
      r = '0;
    end else if (s >= DOT_ONE) begin
      r = Q14_ONE;
    end else begin
      r = s[28:14];
    end
    return r;
  endfunction

  function automatic item_t f_prod(input item_t it);
    item_t o;
    logic signed [33:0] v;
    o = it;
    for (int k = 0; k < 3; k++) begin
      o.t[k] = sx17(it.n[k]) * sx16(it.ray[k]);
      v = -sx16(it.ray[k]);
      o.vec[k] = v[16:0];
      o.u[k] = v * v;
    end
    return o;
  endfunction

  function automatic item_t f_flip(input item_t it, input logic back);
    item_t o;
    logic signed [33:0] d;
    o = it;
    d = $signed(it.t[0]) + $signed(it.t[1]) + $signed(it.t[2]);
    if (back && d > 34'sd0) begin
      for (int k = 0; k < 3; k++) begin
        o.n[k] = -it.n[k];
      end
    end
    o.sqa = {1'b0, it.u[0]} + {1'b0, it.u[1]} + {1'b0, it.u[2]};
    o.sqr = '0;
    return o;
  endfunction

  function automatic item_t sqrt_step(input item_t it, input int sh);
    item_t o;
    logic [34:0] bitv;
    logic [34:0] trial;
    o = it;
    bitv = 35'd1 << sh;
    trial = it.sqr + bitv;
    if (it.sqa >= trial) begin
      o.sqa = it.sqa - trial;
      o.sqr = (it.sqr >> 1) + bitv;
    end else begin
      o.sqr = it.sqr >> 1;
    end
    return o;
  endfunction

  function automatic item_t div_init(input item_t it);
    item_t o;
    logic [16:0] mag;
    o = it;
    o.len = it.sqr[16:0];
    for (int k = 0; k < 3; k++) begin
      mag = it.vec[k][16] ? -it.vec[k] : it.vec[k];
      o.rem[k] = {1'b0, mag, 14'b0};
      o.quo[k] = '0;
    end
    return o;
  endfunction

  function automatic item_t div_step(input item_t it, input int sh);
    item_t o;
    logic [31:0] d;
    o = it;
    d = {15'b0, it.len} << sh;
    for (int k = 0; k < 3; k++) begin
      if (it.rem[k] >= d) begin
        o.rem[k] = it.rem[k] - d;
        o.quo[k][sh] = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic item_t div_fin_v(input item_t it);
    item_t o;
    logic [16:0] q;
    o = it;
    for (int k = 0; k < 3; k++) begin
      q = (it.len == '0) ? '0 : {2'b0, it.quo[k]};
      if (it.vec[k][16]) begin
        q = -q;
      end
      o.vec[k] = {it.l[k][15], it.l[k]} + q;
    end
    return o;
  endfunction

  function automatic item_t f_hsq(input item_t it);
    item_t o;
    o = it;
    for (int k = 0; k < 3; k++) begin
      o.u[k] = sx17(it.vec[k]) * sx17(it.vec[k]);
    end
    return o;
  endfunction

  function automatic item_t f_hsum(input item_t it);
    item_t o;
    o = it;
    o.sqa = {1'b0, it.u[0]} + {1'b0, it.u[1]} + {1'b0, it.u[2]};
    o.sqr = '0;
    return o;
  endfunction

  function automatic item_t div_fin_h(input item_t it);
    item_t o;
    logic [15:0] q;
    o = it;
    for (int k = 0; k < 3; k++) begin
      q = (it.len == '0) ? '0 : {1'b0, it.quo[k]};
      if (it.vec[k][16]) begin
        q = -q;
      end
      o.hn[k] = q;
    end
    return o;
  endfunction

  function automatic item_t f_dot(input item_t it);
    item_t o;
    o = it;
    for (int k = 0; k < 3; k++) begin
      o.t[k] = sx17(it.n[k]) * sx16(it.l[k]);
      o.u[k] = sx17(it.n[k]) * sx16(it.hn[k]);
    end
    return o;
  endfunction

  function automatic item_t f_clamp(input item_t it);
    item_t o;
    logic [14:0] b;
    o = it;
    o.dif = clampd(it.t[0], it.t[1], it.t[2]);
    b = clampd(it.u[0], it.u[1], it.u[2]);
    o.pw_p = Q14_ONE;
    o.pw_s = b;
    o.pw_r = b;
    return o;
  endfunction

  function automatic item_t f_pint(input item_t it, input logic e);
    item_t o;
    o = it;
    if (e) begin
      o.pw_p = mulq(it.pw_p, it.pw_s);
    end
    o.pw_s = mulq(it.pw_s, it.pw_s);
    return o;
  endfunction

  function automatic item_t f_frinit(input item_t it);
    item_t o;
    o = it;
    o.sqa = {6'b0, it.pw_r, 14'b0};
    o.sqr = '0;
    return o;
  endfunction

  function automatic item_t f_frmul(input item_t it, input logic e);
    item_t o;
    logic [14:0] rn;
    o = it;
    rn = it.sqr[14:0];
    if (e) begin
      o.pw_p = mulq(it.pw_p, rn);
    end
    o.pw_r = rn;
    o.sqa = {6'b0, rn, 14'b0};
    o.sqr = '0;
    return o;
  endfunction

  function automatic item_t f_ch1(input item_t it, input logic [2:0][15:0] kd,
                                  input logic [2:0][15:0] ks);
    item_t o;
    o = it;
    for (int c = 0; c < 3; c++) begin
      o.cd[c] = {17'b0, it.dif} * {16'b0, kd[c]} + {17'b0, it.pw_p} * {16'b0, ks[c]};
    end
    return o;
  endfunction

  function automatic item_t f_ch2(input item_t it);
    item_t o;
    o = it;
    for (int c = 0; c < 3; c++) begin
      o.cp[c] = {16'b0, it.cd[c]} * {32'b0, it.lc[c]};
    end
    return o;
  endfunction

  function automatic item_t f_ch3(input item_t it);
    item_t o;
    o = it;
    for (int c = 0; c < 3; c++) begin
      o.res[c] = (|it.cp[c][47:44]) ? 16'hFFFF : it.cp[c][43:28];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/phong_blinn_shading_top.sv @@
// Blinn-Phong shading pipeline: one sample per clock.
// A sample is taken on every clock with start high; busy never rises. The shaded word
// shows with out_valid for one cycle when the sample leaves the last pipeline register,
// stage_r[NSTAGE-1]; it cannot be held off. Most of the stages belong to the eight
// chained one-bit-per-stage square root units of the fractional exponent, behind two
// normalizations that each use a bit-serial square root and restoring divider unrolled
// into stages. Material registers are sampled by the stages that use them, so write them
// only with the pipeline empty.
`default_nettype none
module phong_blinn_shading_top import pbs_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire signed [15:0]  in_normal_x,
  input  wire signed [15:0]  in_normal_y,
  input  wire signed [15:0]  in_normal_z,
  input  wire signed [15:0]  in_ray_dir_x,
  input  wire signed [15:0]  in_ray_dir_y,
  input  wire signed [15:0]  in_ray_dir_z,
  input  wire signed [15:0]  in_light_dir_x,
  input  wire signed [15:0]  in_light_dir_y,
  input  wire signed [15:0]  in_light_dir_z,
  input  wire [15:0]         in_light_red,
  input  wire [15:0]         in_light_green,
  input  wire [15:0]         in_light_blue,
  output logic               out_valid,
  output logic [15:0]        out_shaded_red,
  output logic [15:0]        out_shaded_green,
  output logic [15:0]        out_shaded_blue,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [ADDR_W-1:0]   paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [2:0][15:0] kd_r;
  logic [2:0][15:0] ks_r;
  logic [15:0]      shin_r;
  logic             back_r;
  logic             cfg_we;

  item_t            s0;
  item_t            stage_nxt [NSTAGE];
  item_t            stage_r   [NSTAGE];
  logic [NSTAGE-1:0] valid_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kd_r   <= '0;
      ks_r   <= '0;
      shin_r <= SHIN_RESET;
      back_r <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_DIFFUSE_RED:    kd_r[0] <= pwdata[15:0];
        REG_DIFFUSE_GREEN:  kd_r[1] <= pwdata[15:0];
        REG_DIFFUSE_BLUE:   kd_r[2] <= pwdata[15:0];
        REG_SPECULAR_RED:   ks_r[0] <= pwdata[15:0];
        REG_SPECULAR_GREEN: ks_r[1] <= pwdata[15:0];
        REG_SPECULAR_BLUE:  ks_r[2] <= pwdata[15:0];
        REG_SHININESS:      shin_r  <= pwdata[15:0];
        REG_SHADE_BACK:     back_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DIFFUSE_RED:    prdata = {16'b0, kd_r[0]};
      REG_DIFFUSE_GREEN:  prdata = {16'b0, kd_r[1]};
      REG_DIFFUSE_BLUE:   prdata = {16'b0, kd_r[2]};
      REG_SPECULAR_RED:   prdata = {16'b0, ks_r[0]};
      REG_SPECULAR_GREEN: prdata = {16'b0, ks_r[1]};
      REG_SPECULAR_BLUE:  prdata = {16'b0, ks_r[2]};
      REG_SHININESS:      prdata = {16'b0, shin_r};
      REG_SHADE_BACK:     prdata = {31'b0, back_r};
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    s0 = '0;
    s0.n[0]   = {in_normal_x[15], in_normal_x};
    s0.n[1]   = {in_normal_y[15], in_normal_y};
    s0.n[2]   = {in_normal_z[15], in_normal_z};
    s0.ray[0] = in_ray_dir_x;
    s0.ray[1] = in_ray_dir_y;
    s0.ray[2] = in_ray_dir_z;
    s0.l[0]   = in_light_dir_x;
    s0.l[1]   = in_light_dir_y;
    s0.l[2]   = in_light_dir_z;
    s0.lc[0]  = in_light_red;
    s0.lc[1]  = in_light_green;
    s0.lc[2]  = in_light_blue;
  end

  assign stage_nxt[0] = s0;

  for (genvar i = 1; i < NSTAGE; i++) begin : g_stage
    if (i == ST_PROD) begin : g_op
      assign stage_nxt[i] = f_prod(stage_r[i-1]);
    end else if (i == ST_FLIP) begin : g_op
      assign stage_nxt[i] = f_flip(stage_r[i-1], back_r);
    end else if (i >= ST_SQV0 && i < ST_DIVV_INIT) begin : g_op
      assign stage_nxt[i] = sqrt_step(stage_r[i-1], 2 * (SQV_STEPS - 1 - (i - ST_SQV0)));
    end else if (i == ST_DIVV_INIT || i == ST_DIVH_INIT) begin : g_op
      assign stage_nxt[i] = div_init(stage_r[i-1]);
    end else if (i >= ST_DIVV0 && i < ST_DIVV_FIN) begin : g_op
      assign stage_nxt[i] = div_step(stage_r[i-1], DIV_STEPS - 1 - (i - ST_DIVV0));
    end else if (i == ST_DIVV_FIN) begin : g_op
      assign stage_nxt[i] = div_fin_v(stage_r[i-1]);
    end else if (i == ST_HSQ) begin : g_op
      assign stage_nxt[i] = f_hsq(stage_r[i-1]);
    end else if (i == ST_HSUM) begin : g_op
      assign stage_nxt[i] = f_hsum(stage_r[i-1]);
    end else if (i >= ST_SQH0 && i < ST_DIVH_INIT) begin : g_op
      assign stage_nxt[i] = sqrt_step(stage_r[i-1], 2 * (SQH_STEPS - 1 - (i - ST_SQH0)));
    end else if (i >= ST_DIVH0 && i < ST_DIVH_FIN) begin : g_op
      assign stage_nxt[i] = div_step(stage_r[i-1], DIV_STEPS - 1 - (i - ST_DIVH0));
    end else if (i == ST_DIVH_FIN) begin : g_op
      assign stage_nxt[i] = div_fin_h(stage_r[i-1]);
    end else if (i == ST_DOT) begin : g_op
      assign stage_nxt[i] = f_dot(stage_r[i-1]);
    end else if (i == ST_CLAMP) begin : g_op
      assign stage_nxt[i] = f_clamp(stage_r[i-1]);
    end else if (i >= ST_PINT0 && i < ST_FRINIT) begin : g_op
      assign stage_nxt[i] = f_pint(stage_r[i-1], shin_r[8 + (i - ST_PINT0)]);
    end else if (i == ST_FRINIT) begin : g_op
      assign stage_nxt[i] = f_frinit(stage_r[i-1]);
    end else if (i >= ST_FR0 && i < ST_CH1) begin : g_op
      localparam int FJ = (i - ST_FR0) % FR_ROUND;
      localparam int FK = (i - ST_FR0) / FR_ROUND;
      if (FJ < FR_STEPS) begin : g_sq
        assign stage_nxt[i] = sqrt_step(stage_r[i-1], 2 * (FR_STEPS - 1 - FJ));
      end else begin : g_mul
        assign stage_nxt[i] = f_frmul(stage_r[i-1], shin_r[FR_ROUNDS - 1 - FK]);
      end
    end else if (i == ST_CH1) begin : g_op
      assign stage_nxt[i] = f_ch1(stage_r[i-1], kd_r, ks_r);
    end else if (i == ST_CH2) begin : g_op
      assign stage_nxt[i] = f_ch2(stage_r[i-1]);
    end else begin : g_op
      assign stage_nxt[i] = f_ch3(stage_r[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[NSTAGE-2:0], start & ~busy};
    end
  end

  assign out_valid        = valid_r[NSTAGE-1];
  assign out_shaded_red   = stage_r[NSTAGE-1].res[0];
  assign out_shaded_green = stage_r[NSTAGE-1].res[1];
  assign out_shaded_blue  = stage_r[NSTAGE-1].res[2];

endmodule
`default_nettype wire

@@ rtl/core/pbs_checker.sv @@
// Port-level checker for the shading pipeline, bound to the top level
`default_nettype none
module pbs_checker import pbs_pkg::*; (
  input wire              clk,
  input wire              rst_n,
  input wire              start,
  input wire              busy,
  input wire              out_valid,
  input wire              psel,
  input wire              penable,
  input wire              pwrite,
  input wire [ADDR_W-1:0] paddr,
  input wire [31:0]       pwdata,
  input wire [31:0]       prdata,
  input wire              pready
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  a_word_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, NSTAGE))
    else $error("result word without matching sample");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(psel && penable && pwrite && rst_n) && paddr == $past(paddr)) |->
      prdata == ((paddr[4:2] == REG_SHADE_BACK) ? {31'b0, $past(pwdata[0])}
                                                : {16'b0, $past(pwdata[15:0])}))
    else $error("register readback mismatch");

endmodule

bind phong_blinn_shading_top pbs_checker u_pbs_checker (.*);
`default_nettype wire
